[hdl/vqlc_pkg.sv]
// Shared types, constants and profile tables for the video quality level controller.
package vqlc_pkg;

  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned COUNT_W = 3;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam level_t LEVEL_BEST  = 3'd0;
  localparam level_t LEVEL_WORST = 3'd4;

  // loss thresholds (tenths of a percent) for the required level
  localparam logic [9:0] LOSS_L4 = 10'd600;
  localparam logic [9:0] LOSS_L3 = 10'd300;
  localparam logic [9:0] LOSS_L2 = 10'd100;
  localparam logic [9:0] LOSS_L1 = 10'd30;

  // time thresholds (tenths of a millisecond)
  localparam logic [15:0] RTT_L3      = 16'd3500;
  localparam logic [15:0] RTT_L2      = 16'd1800;
  localparam logic [15:0] JIT_L1      = 16'd500;
  localparam logic [15:0] RTT_RECOVER = 16'd1500;
  localparam logic [15:0] JIT_RECOVER = 16'd400;

  localparam logic [10:0] CAP_MIN   = 11'd150;
  localparam logic [10:0] CAP_MAX   = 11'd2000;
  localparam logic [10:0] CAP_RESET = 11'd2000;

  typedef struct packed {
    logic [9:0]  loss_tenths;
    logic [9:0]  transport_loss_tenths;
    logic [15:0] rtt_tenths_ms;
    logic [15:0] jitter_tenths_ms;
  } vqlc_in_t;

  typedef struct packed {
    logic [2:0]  quality_level;
    logic [10:0] stream_kbps;
    logic [4:0]  frame_rate;
    logic [10:0] frame_width;
    logic [9:0]  frame_height;
  } vqlc_out_t;

  // what one report says, passed from the assessment to the level tracker
  typedef struct packed {
    level_t     req_level;
    logic [9:0] loss;
    logic       rtt_ok;
    logic       jit_ok;
  } vqlc_assess_t;

  // recovery loss limit (strictly below) for the current level
  function automatic logic [9:0] recover_loss(input level_t lv);
    logic [9:0] v;
    unique case (lv)
      3'd0:    v = 10'd0;
      3'd1:    v = 10'd10;
      3'd2:    v = 10'd70;
      3'd3:    v = 10'd250;
      default: v = 10'd500;
    endcase
    return v;
  endfunction

  function automatic logic [10:0] prof_rate(input level_t lv);
    logic [10:0] v;
    unique case (lv)
      3'd0:    v = 11'd2000;
      3'd1:    v = 11'd1200;
      3'd2:    v = 11'd600;
      3'd3:    v = 11'd300;
      default: v = 11'd150;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] prof_fps(input level_t lv);
    logic [4:0] v;
    unique case (lv)
      3'd0:    v = 5'd30;
      3'd1:    v = 5'd24;
      3'd2:    v = 5'd15;
      3'd3:    v = 5'd10;
      default: v = 5'd5;
    endcase
    return v;
  endfunction

  function automatic logic [10:0] prof_width(input level_t lv);
    logic [10:0] v;
    unique case (lv)
      3'd0:    v = 11'd1280;
      3'd1:    v = 11'd960;
      3'd2:    v = 11'd640;
      3'd3:    v = 11'd426;
      default: v = 11'd320;
    endcase
    return v;
  endfunction

  function automatic logic [9:0] prof_height(input level_t lv);
    logic [9:0] v;
    unique case (lv)
      3'd0:    v = 10'd720;
      3'd1:    v = 10'd540;
      3'd2:    v = 10'd360;
      3'd3:    v = 10'd240;
      default: v = 10'd180;
    endcase
    return v;
  endfunction

endpackage

[hdl/vqlc_assess.sv]
// Report assessment: worst loss, required level and recovery time checks.
module vqlc_assess (
  input  vqlc_pkg::vqlc_in_t     report,
  output vqlc_pkg::vqlc_assess_t assess
);
  import vqlc_pkg::*;

  logic [9:0] loss;
  level_t     lv_loss;
  level_t     lv_rtt;
  level_t     lv_req;

  assign loss = (report.loss_tenths > report.transport_loss_tenths) ?
                report.loss_tenths : report.transport_loss_tenths;

  always_comb begin
    priority if (loss > LOSS_L4) lv_loss = 3'd4;
    else if (loss > LOSS_L3)     lv_loss = 3'd3;
    else if (loss > LOSS_L2)     lv_loss = 3'd2;
    else if (loss > LOSS_L1)     lv_loss = 3'd1;
    else                         lv_loss = LEVEL_BEST;

    lv_rtt = lv_loss;
    priority if (report.rtt_tenths_ms > RTT_L3) begin
      if (lv_loss < 3'd3) lv_rtt = 3'd3;
    end else if (report.rtt_tenths_ms > RTT_L2) begin
      if (lv_loss < 3'd2) lv_rtt = 3'd2;
    end else begin
      lv_rtt = lv_loss;
    end

    lv_req = lv_rtt;
    if (report.jitter_tenths_ms > JIT_L1 && lv_rtt == LEVEL_BEST) lv_req = 3'd1;
  end

  assign assess.req_level = lv_req;
  assign assess.loss      = loss;
  assign assess.rtt_ok    = report.rtt_tenths_ms < RTT_RECOVER;
  assign assess.jit_ok    = report.jitter_tenths_ms < JIT_RECOVER;

endmodule

[hdl/vqlc_level.sv]
// Level tracker: current level and good-report count with rise and recovery rules.
module vqlc_level #(
  parameter int unsigned RECOVERY_REPORTS = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   advance,
  input  vqlc_pkg::vqlc_assess_t assess,
  output vqlc_pkg::level_t       level_nxt
);
  import vqlc_pkg::*;

  level_t level_r;
  count_t count_r;
  count_t count_nxt;
  count_t count_inc;
  logic   good;

  assign count_inc = COUNT_W'(count_r + 1'b1);
  assign good = (level_r != LEVEL_BEST) && (assess.loss < recover_loss(level_r)) &&
                assess.rtt_ok && assess.jit_ok;

  always_comb begin
    level_nxt = level_r;
    count_nxt = '0;
    priority if (assess.req_level > level_r) begin
      level_nxt = assess.req_level;
    end else if (good) begin
      if (count_inc >= COUNT_W'(RECOVERY_REPORTS)) begin
        level_nxt = level_r - 3'd1;
      end else begin
        count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= LEVEL_BEST;
      count_r <= '0;
    end else if (advance) begin
      level_r <= level_nxt;
      count_r <= count_nxt;
    end
  end

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LEVEL_WORST)
    else $error("level above worst profile");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < COUNT_W'(RECOVERY_REPORTS))
    else $error("good-report count reached recovery length");

  // recovery only ever steps down by one level per request
  a_step_down: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (level_nxt < level_r) |=> (level_r + 3'd1 == $past(level_r)))
    else $error("level dropped by more than one");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(level_r) && $stable(count_r))
    else $error("state changed without a request");

endmodule

[hdl/video_quality_level_controller.sv]
// Top level: input register, assessment, level tracking and profile output register.
//
//  channel | ports                            | direction
//  --------+----------------------------------+----------
//  input   | in_valid, in_stall, in_data      | in
//  result  | out_valid, out_stall, out_data   | out
//  config  | cfg_we, cfg_wdata                | in
//
// One request per cycle while in_stall is low; each result passes through the input register
// and then the result register. The level update between them is a few compares and a
// five-entry profile lookup.
// Synchronous active-low reset: level 0, count 0, cap 2000, both stages empty.
// out_stall holds the result register; the input stage still takes a request while
// it is empty, so in_stall rises only when both stages are full.
module video_quality_level_controller #(
  parameter int unsigned RECOVERY_REPORTS = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vqlc_pkg::vqlc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output vqlc_pkg::vqlc_out_t out_data,
  input  logic                cfg_we,
  input  logic [10:0]         cfg_wdata
);
  import vqlc_pkg::*;

  logic         s1_valid_r;
  vqlc_in_t     s1_data_r;
  logic         out_valid_r;
  vqlc_out_t    out_data_r;
  logic [10:0]  cap_r;
  logic [10:0]  cap;
  logic         out_load;
  logic         s1_load;
  vqlc_assess_t assess;
  level_t       level_nxt;
  logic [10:0]  rate;

  assign out_load = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !out_load;
  assign s1_load  = in_valid && !in_stall;

  vqlc_assess u_assess (
    .report (s1_data_r),
    .assess (assess)
  );

  vqlc_level #(
    .RECOVERY_REPORTS (RECOVERY_REPORTS)
  ) u_level (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (out_load),
    .assess    (assess),
    .level_nxt (level_nxt)
  );

  always_comb begin
    cap = cap_r;
    if (cap_r < CAP_MIN) cap = CAP_MIN;
    if (cap_r > CAP_MAX) cap = CAP_MAX;
    rate = prof_rate(level_nxt);
    if (rate > cap) rate = cap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RESET;
    end else begin
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (out_load) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_data_r <= in_data;
    end
    if (out_load) begin
      out_data_r.quality_level <= level_nxt;
      out_data_r.stream_kbps   <= rate;
      out_data_r.frame_rate    <= prof_fps(level_nxt);
      out_data_r.frame_width   <= prof_width(level_nxt);
      out_data_r.frame_height  <= prof_height(level_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !out_load)
    else $error("result overwritten while stalled");

  a_rate_capped: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_data_r.stream_kbps <= CAP_MAX &&
                 out_data_r.stream_kbps >= CAP_MIN)
    else $error("bitrate outside cap range");

  a_in_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with a free stage");

endmodule

[test/video_quality_level_controller_tb.sv]
// Self-checking testbench for video_quality_level_controller: directed table, then random phases.
module video_quality_level_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vqlc_pkg::*;

  localparam int unsigned GOOD_RUN          = 5;
  localparam int unsigned PHASES            = 8;
  localparam int unsigned REPORTS_PER_PHASE = 155;
  localparam int unsigned HOLD_CYCLES       = 80;

  localparam vqlc_out_t TOP_PROFILE   = {LEVEL_BEST, 11'd2000, 5'd30, 11'd1280, 10'd720};
  localparam vqlc_out_t FLOOR_PROFILE = {LEVEL_WORST, 11'd150, 5'd5, 11'd320, 10'd180};
  localparam vqlc_out_t NO_PROFILE    = '0;

  typedef struct packed {
    vqlc_in_t  rpt;
    logic      typed;
    vqlc_out_t want;
  } report_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  vqlc_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  vqlc_out_t   out_data;
  logic        cfg_we;
  logic [10:0] cfg_wdata;

  // shadow of the block state
  level_t      cur_level;
  count_t      good_count;
  logic [10:0] cap_kbps;

  vqlc_out_t   profile_q[$];
  report_row_t dir_rows[$];
  vqlc_out_t   want_prof;
  int          errors;
  int          send_idle_pct;
  int          stall_pct;
  int          hold_left;

  int loss_marks [23] = '{0, 9, 10, 29, 30, 31, 69, 70, 99, 100, 101, 249, 250, 299, 300,
                          301, 499, 500, 599, 600, 601, 1000, 1023};
  int rtt_marks  [11] = '{0, 1499, 1500, 1501, 1799, 1800, 1801, 3499, 3500, 3501, 65535};
  int jit_marks  [8]  = '{0, 399, 400, 401, 499, 500, 501, 65535};

  video_quality_level_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [9:0] recovery_limit(input level_t lv);
    case (lv)
      3'd0:    return 10'd0;
      3'd1:    return 10'd10;
      3'd2:    return 10'd70;
      3'd3:    return 10'd250;
      default: return 10'd500;
    endcase
  endfunction

  function automatic vqlc_out_t level_profile(input level_t lv);
    vqlc_out_t   p;
    logic [10:0] cap;
    cap = cap_kbps;
    if (cap < CAP_MIN) cap = CAP_MIN;
    if (cap > CAP_MAX) cap = CAP_MAX;
    p.quality_level = lv;
    case (lv)
      3'd0:    begin p.stream_kbps = 11'd2000; p.frame_rate = 5'd30;
                     p.frame_width = 11'd1280; p.frame_height = 10'd720; end
      3'd1:    begin p.stream_kbps = 11'd1200; p.frame_rate = 5'd24;
                     p.frame_width = 11'd960;  p.frame_height = 10'd540; end
      3'd2:    begin p.stream_kbps = 11'd600;  p.frame_rate = 5'd15;
                     p.frame_width = 11'd640;  p.frame_height = 10'd360; end
      3'd3:    begin p.stream_kbps = 11'd300;  p.frame_rate = 5'd10;
                     p.frame_width = 11'd426;  p.frame_height = 10'd240; end
      default: begin p.stream_kbps = 11'd150;  p.frame_rate = 5'd5;
                     p.frame_width = 11'd320;  p.frame_height = 10'd180; end
    endcase
    if (p.stream_kbps > cap) p.stream_kbps = cap;
    return p;
  endfunction

  // advances the shadow level tracker by one report and returns the new profile
  function automatic vqlc_out_t apply_report(input vqlc_in_t r);
    logic [9:0] worst;
    level_t     need;
    level_t     lv;
    worst = (r.loss_tenths > r.transport_loss_tenths) ? r.loss_tenths
                                                      : r.transport_loss_tenths;
    need = LEVEL_BEST;
    if (worst > LOSS_L4)      need = LEVEL_WORST;
    else if (worst > LOSS_L3) need = 3'd3;
    else if (worst > LOSS_L2) need = 3'd2;
    else if (worst > LOSS_L1) need = 3'd1;
    if (r.rtt_tenths_ms > RTT_L3) begin
      if (need < 3'd3) need = 3'd3;
    end else if (r.rtt_tenths_ms > RTT_L2) begin
      if (need < 3'd2) need = 3'd2;
    end
    if (r.jitter_tenths_ms > JIT_L1 && need < 3'd1) need = 3'd1;
    lv = cur_level;
    if (need > lv) begin
      cur_level  = need;
      good_count = '0;
    end else if (lv != LEVEL_BEST && worst < recovery_limit(lv) &&
                 r.rtt_tenths_ms < RTT_RECOVER && r.jitter_tenths_ms < JIT_RECOVER) begin
      good_count = good_count + 1'b1;
      if (good_count >= GOOD_RUN) begin
        cur_level  = lv - 1'b1;
        good_count = '0;
      end
    end else begin
      good_count = '0;
    end
    return level_profile(cur_level);
  endfunction

  task automatic add_row(input int l1, input int l2, input int rtt, input int jit,
                         input logic typed, input vqlc_out_t want);
    report_row_t row;
    row.rpt   = {l1[9:0], l2[9:0], rtt[15:0], jit[15:0]};
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_report(input vqlc_in_t r, input logic typed, input vqlc_out_t want);
    vqlc_out_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = apply_report(r);
    profile_q.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (profile_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_cap(input logic [10:0] v);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    cap_kbps   = v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left  = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (profile_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result lvl=%0d kbps=%0d fps=%0d %0dx%0d", $time,
                 out_data.quality_level, out_data.stream_kbps, out_data.frame_rate,
                 out_data.frame_width, out_data.frame_height);
      end else begin
        want_prof = profile_q.pop_front();
        if (out_data.quality_level !== want_prof.quality_level ||
            out_data.stream_kbps   !== want_prof.stream_kbps   ||
            out_data.frame_rate    !== want_prof.frame_rate    ||
            out_data.frame_width   !== want_prof.frame_width   ||
            out_data.frame_height  !== want_prof.frame_height) begin
          errors++;
          $display("%0t: expected %0d/%0d/%0d/%0dx%0d, actual %0d/%0d/%0d/%0dx%0d",
                   $time, want_prof.quality_level, want_prof.stream_kbps,
                   want_prof.frame_rate, want_prof.frame_width, want_prof.frame_height,
                   out_data.quality_level, out_data.stream_kbps, out_data.frame_rate,
                   out_data.frame_width, out_data.frame_height);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("video_quality_level_controller verification failed");
    $finish;
  end

  initial begin : stimulus
    int          n;
    int          k;
    int          run;
    int          p;
    logic [9:0]  lim;
    vqlc_in_t    r;
    logic [10:0] caps [8];

    caps = '{11'd0, 11'd2047, 11'd150, 11'd149, 11'd2000, 11'd1201, 11'd301, 11'd1999};
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    errors        = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 0;
    cur_level     = LEVEL_BEST;
    good_count    = '0;
    cap_kbps      = CAP_RESET;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: thresholds and their neighbors, recovery from the worst level
    add_row(0, 0, 0, 0, 1'b1, TOP_PROFILE);
    add_row(1023, 0, 0, 0, 1'b1, FLOOR_PROFILE);
    add_row(0, 1023, 65535, 65535, 1'b1, FLOOR_PROFILE);
    repeat (GOOD_RUN) add_row(499, 0, 1499, 399, 1'b0, NO_PROFILE);
    add_row(0, 0, 3500, 500, 1'b0, NO_PROFILE);
    add_row(0, 0, 3501, 0, 1'b0, NO_PROFILE);
    add_row(30, 30, 1800, 0, 1'b0, NO_PROFILE);
    add_row(0, 600, 0, 0, 1'b0, NO_PROFILE);
    add_row(601, 0, 0, 0, 1'b1, FLOOR_PROFILE);
    add_row(0, 0, 1500, 0, 1'b0, NO_PROFILE);
    add_row(0, 0, 0, 400, 1'b0, NO_PROFILE);
    add_row(101, 100, 0, 0, 1'b0, NO_PROFILE);
    add_row(31, 0, 0, 501, 1'b0, NO_PROFILE);
    add_row(10'h2AA, 10'h155, 16'hAAAA, 16'h5555, 1'b1, FLOOR_PROFILE);
    add_row(10'h155, 10'h2AA, 16'h5555, 16'hAAAA, 1'b1, FLOOR_PROFILE);
    add_row(301, 300, 1801, 499, 1'b0, NO_PROFILE);
    foreach (dir_rows[i]) send_report(dir_rows[i].rpt, dir_rows[i].typed, dir_rows[i].want);
    in_valid <= 1'b0;

    for (p = 0; p < PHASES; p++) begin
      set_cap(caps[p]);
      case (p % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 61; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 61; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      // long receiver hold-off while requests keep coming, so the block backs up
      if (p == 2) begin
        stall_pct = 0;
        hold_left = HOLD_CYCLES;
      end
      n = 0;
      while (n < REPORTS_PER_PHASE) begin
        k = $urandom_range(99);
        if (k < 45) begin
          run = $urandom_range(7, 4);
          repeat (run) begin
            lim = recovery_limit(cur_level);
            r.loss_tenths           = (lim == 0) ? 10'd0 : 10'($urandom_range(lim - 1));
            r.transport_loss_tenths = (lim == 0) ? 10'd0 : 10'($urandom_range(lim - 1));
            r.rtt_tenths_ms         = 16'($urandom_range(1499));
            r.jitter_tenths_ms      = 16'($urandom_range(399));
            send_report(r, 1'b0, NO_PROFILE);
            n++;
          end
        end else if (k < 60) begin
          r.loss_tenths           = 10'($urandom_range(1023));
          r.transport_loss_tenths = 10'($urandom_range(120));
          r.rtt_tenths_ms         = 16'($urandom_range(4000));
          r.jitter_tenths_ms      = 16'($urandom_range(600));
          if (k[0]) {r.loss_tenths, r.transport_loss_tenths} =
                      {r.transport_loss_tenths, r.loss_tenths};
          send_report(r, 1'b0, NO_PROFILE);
          n++;
        end else if (k < 80) begin
          r.loss_tenths           = 10'(loss_marks[$urandom_range(22)]);
          r.transport_loss_tenths = k[0] ? 10'(loss_marks[$urandom_range(22)]) : 10'd0;
          r.rtt_tenths_ms         = 16'(rtt_marks[$urandom_range(10)]);
          r.jitter_tenths_ms      = 16'(jit_marks[$urandom_range(7)]);
          send_report(r, 1'b0, NO_PROFILE);
          n++;
        end else begin
          r.loss_tenths           = 10'($urandom);
          r.transport_loss_tenths = 10'($urandom);
          r.rtt_tenths_ms         = 16'($urandom);
          r.jitter_tenths_ms      = 16'($urandom);
          send_report(r, 1'b0, NO_PROFILE);
          n++;
        end
      end
      in_valid <= 1'b0;
    end

    wait_drained();
    repeat (6) @(negedge clk);
    if (errors == 0) begin
      $display("video_quality_level_controller verification clean");
    end else begin
      $display("video_quality_level_controller verification failed");
    end
    $finish;
  end

endmodule
